// File: src/rah_pkg.sv
// Shared types for the ray / axis-aligned rectangle hit pipeline.
// No dependencies; imported by ray_axis_aligned_rect_hit_top and its testbench.
package rah_pkg;

    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_PLANE_AXIS   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PLANE_OFFSET = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_LOW    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_HIGH   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SECOND_LOW   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_SECOND_HIGH  = 3'd5;

    localparam logic [1:0] AXIS_XY = 2'd0;
    localparam logic [1:0] AXIS_XZ = 2'd1;
    localparam logic [1:0] AXIS_YZ = 2'd2;

    // quotient bits of the t divider and of the u/v dividers
    localparam int TQW  = 33;
    localparam int UVQW = 17;

    typedef struct packed {
        logic               vld;
        logic               miss;
        logic               neg;
        logic               front;
        logic signed [31:0] org_a;
        logic signed [31:0] org_b;
        logic signed [31:0] dir_a;
        logic signed [31:0] dir_b;
        logic signed [31:0] t_lo;
        logic signed [31:0] t_hi;
    } side_a_t;

    typedef struct packed {
        logic               vld;
        logic               miss;
        logic               front;
        logic signed [31:0] org_a;
        logic signed [31:0] org_b;
        logic signed [31:0] dir_a;
        logic signed [31:0] dir_b;
        logic signed [31:0] t;
    } side_b_t;

    typedef struct packed {
        logic               vld;
        logic               miss;
        logic               front;
        logic signed [31:0] org_a;
        logic signed [31:0] org_b;
        logic signed [31:0] t;
        logic signed [63:0] prod_a;
        logic signed [63:0] prod_b;
    } side_c_t;

    typedef struct packed {
        logic               vld;
        logic               miss;
        logic               front;
        logic signed [31:0] t;
        logic signed [48:0] p_a;
        logic signed [48:0] p_b;
    } side_d_t;

    typedef struct packed {
        logic               vld;
        logic               miss;
        logic               front;
        logic signed [31:0] t;
        logic signed [31:0] p_a;
        logic signed [31:0] p_b;
    } side_e_t;

endpackage

// File: src/rah_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; caller guarantees dividend[DVD_W-1:Q_W] < divisor.
module rah_div_pipe
#(
    parameter int DVD_W = 49,
    parameter int DVS_W = 32,
    parameter int Q_W   = 33
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient
);

    logic [DVS_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [DVS_W-1:0] dvs_reg [Q_W];

    genvar i;
    generate
        for (i = 0; i < Q_W; i++)
        begin : g_stage
            logic [DVS_W-1:0] rem_in;
            logic [Q_W-1:0]   quo_in;
            logic [DVS_W-1:0] dvs_in;
            logic [DVS_W:0]   cand;
            logic [DVS_W:0]   diff;
            logic             ge;
            logic [DVS_W-1:0] rem_next;
            logic [Q_W-1:0]   quo_next;

            if (i == 0)
            begin : g_first
                assign rem_in = DVS_W'(dividend[DVD_W-1:Q_W]);
                assign quo_in = dividend[Q_W-1:0];
                assign dvs_in = divisor;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign quo_in = quo_reg[i-1];
                assign dvs_in = dvs_reg[i-1];
            end

            assign cand     = {rem_in, quo_in[Q_W-1]};
            assign diff     = cand - {1'b0, dvs_in};
            assign ge       = (cand >= {1'b0, dvs_in});
            assign rem_next = ge ? diff[DVS_W-1:0] : cand[DVS_W-1:0];
            assign quo_next = {quo_in[Q_W-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    quo_reg[i] <= quo_next;
                    dvs_reg[i] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[Q_W-1];

endmodule

// File: src/ray_axis_aligned_rect_hit_top.sv
// Top level of the ray / axis-aligned rectangle hit pipeline.
// Depends on rah_pkg and rah_div_pipe.
//
// Tests one ray per cycle, unless the output stalls, against a rectangle in
// the XY, XZ or YZ plane held in configuration registers. Every ray gives
// exactly one result word: on a hit, t (Q16.16), u and v (Q1.16, 0..65536),
// the hit point and front_face; on a miss, all fields zero. A ray passes in
// order through setup, the bit-serial-by-stage t divider, window test,
// multiply, add, bounds test, the u/v dividers and the output register.
// A stall on out_ready freezes the whole pipe, so in_ready drops only while
// a finished word sits unclaimed at the output. Configuration must be
// written only while no ray is in flight; the pipe reads it live.
module ray_axis_aligned_rect_hit_top
    import rah_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_addr,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic signed [31:0]  origin_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  logic signed [31:0]  t_lower,
    input  logic signed [31:0]  t_upper,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic signed [31:0]  t_hit,
    output logic [16:0]         u_coord,
    output logic [16:0]         v_coord,
    output logic signed [31:0]  point_x,
    output logic signed [31:0]  point_y,
    output logic signed [31:0]  point_z,
    output logic                front_face
);

    // ---------------- configuration ----------------
    logic [1:0]         plane_axis_reg;
    logic signed [31:0] plane_offset_reg;
    logic signed [31:0] first_low_reg;
    logic signed [31:0] first_high_reg;
    logic signed [31:0] second_low_reg;
    logic signed [31:0] second_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_axis_reg   <= AXIS_XY;
            plane_offset_reg <= '0;
            first_low_reg    <= '0;
            first_high_reg   <= 32'sd65536;
            second_low_reg   <= '0;
            second_high_reg  <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PLANE_AXIS:   plane_axis_reg   <= cfg_wdata[1:0];
                CFG_PLANE_OFFSET: plane_offset_reg <= cfg_wdata;
                CFG_FIRST_LOW:    first_low_reg    <= cfg_wdata;
                CFG_FIRST_HIGH:   first_high_reg   <= cfg_wdata;
                CFG_SECOND_LOW:   second_low_reg   <= cfg_wdata;
                CFG_SECOND_HIGH:  second_high_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // in-plane spans, to be kept static by the user while rays are in flight; the block does not enforce it
    logic signed [32:0] span_a;
    logic signed [32:0] span_b;
    assign span_a = {first_high_reg[31], first_high_reg} - {first_low_reg[31], first_low_reg};
    assign span_b = {second_high_reg[31], second_high_reg}
                  - {second_low_reg[31], second_low_reg};

    // whole pipe moves together; a full output stage that is not taken freezes it
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage A: pick axes, set up divide ----------------
    logic signed [31:0] org_n, org_a, org_b, dir_n, dir_a, dir_b;
    logic               axis_bad;

    always_comb
    begin
        axis_bad = 1'b0;
        org_n = origin_z; org_a = origin_x; org_b = origin_y;
        dir_n = dir_z;    dir_a = dir_x;    dir_b = dir_y;
        case (plane_axis_reg)
            AXIS_XY:
            begin
                org_n = origin_z; org_a = origin_x; org_b = origin_y;
                dir_n = dir_z;    dir_a = dir_x;    dir_b = dir_y;
            end
            AXIS_XZ:
            begin
                org_n = origin_y; org_a = origin_x; org_b = origin_z;
                dir_n = dir_y;    dir_a = dir_x;    dir_b = dir_z;
            end
            AXIS_YZ:
            begin
                org_n = origin_x; org_a = origin_y; org_b = origin_z;
                dir_n = dir_x;    dir_a = dir_y;    dir_b = dir_z;
            end
            default: axis_bad = 1'b1;
        endcase
    end

    logic signed [32:0] num;
    logic [32:0]        num_mag;
    logic [31:0]        den_mag;
    logic               ovf;
    assign num     = {plane_offset_reg[31], plane_offset_reg} - {org_n[31], org_n};
    assign num_mag = num[32] ? 33'(-num) : 33'(num);
    assign den_mag = dir_n[31] ? 32'(-dir_n) : 32'(dir_n);
    // quotient would need more than TQW bits: t is far outside any 32-bit window
    assign ovf     = (32'(num_mag[32:17]) >= den_mag);

    side_a_t     a_next, a_reg;
    logic [48:0] a_dvd_reg;
    logic [31:0] a_dvs_reg;

    always_comb
    begin
        a_next.vld   = in_valid;
        a_next.miss  = axis_bad || (dir_n == '0) || ovf;
        a_next.neg   = num[32] ^ dir_n[31];
        a_next.front = dir_n[31];
        a_next.org_a = org_a;
        a_next.org_b = org_b;
        a_next.dir_a = dir_a;
        a_next.dir_b = dir_b;
        a_next.t_lo  = t_lower;
        a_next.t_hi  = t_upper;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_reg <= '0;
        else if (en)
            a_reg <= a_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dvd_reg <= {num_mag, 16'b0};
            a_dvs_reg <= den_mag;
        end
    end

    // ---------------- t divider and matching delay line ----------------
    logic [TQW-1:0] t_quo;

    rah_div_pipe #(.DVD_W(49), .DVS_W(32), .Q_W(TQW)) u_div_t
    (
        .clk      (clk),
        .en       (en),
        .dividend (a_dvd_reg),
        .divisor  (a_dvs_reg),
        .quotient (t_quo)
    );

    side_a_t a_dly_reg [TQW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TQW; j++)
                a_dly_reg[j] <= '0;
        end
        else if (en)
        begin
            a_dly_reg[0] <= a_reg;
            for (int j = 1; j < TQW; j++)
                a_dly_reg[j] <= a_dly_reg[j-1];
        end
    end

    // ---------------- stage B: sign and window test ----------------
    side_a_t            a_out;
    logic [33:0]        t_mag;
    logic signed [33:0] t_full;
    logic               win_fail;
    side_b_t            b_reg;

    assign a_out    = a_dly_reg[TQW-1];
    assign t_mag    = {1'b0, t_quo};
    assign t_full   = a_out.neg ? $signed(-t_mag) : $signed(t_mag);
    assign win_fail = (t_full < $signed({{2{a_out.t_lo[31]}}, a_out.t_lo}))
                   || (t_full > $signed({{2{a_out.t_hi[31]}}, a_out.t_hi}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_reg <= '0;
        else if (en)
        begin
            b_reg.vld   <= a_out.vld;
            b_reg.miss  <= a_out.miss || win_fail;
            b_reg.front <= a_out.front;
            b_reg.org_a <= a_out.org_a;
            b_reg.org_b <= a_out.org_b;
            b_reg.dir_a <= a_out.dir_a;
            b_reg.dir_b <= a_out.dir_b;
            b_reg.t     <= t_full[31:0];
        end
    end

    // ---------------- stage C: t * dir ----------------
    side_c_t c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg <= '0;
        else if (en)
        begin
            c_reg.vld    <= b_reg.vld;
            c_reg.miss   <= b_reg.miss;
            c_reg.front  <= b_reg.front;
            c_reg.org_a  <= b_reg.org_a;
            c_reg.org_b  <= b_reg.org_b;
            c_reg.t      <= b_reg.t;
            c_reg.prod_a <= b_reg.t * b_reg.dir_a;
            c_reg.prod_b <= b_reg.t * b_reg.dir_b;
        end
    end

    // ---------------- stage D: point = origin + floor(prod / 2^16) ----------------
    logic signed [63:0] sh_a, sh_b;
    side_d_t            d_reg;

    assign sh_a = c_reg.prod_a >>> 16;
    assign sh_b = c_reg.prod_b >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
        begin
            d_reg.vld   <= c_reg.vld;
            d_reg.miss  <= c_reg.miss;
            d_reg.front <= c_reg.front;
            d_reg.t     <= c_reg.t;
            d_reg.p_a   <= {{17{c_reg.org_a[31]}}, c_reg.org_a} + sh_a[48:0];
            d_reg.p_b   <= {{17{c_reg.org_b[31]}}, c_reg.org_b} + sh_b[48:0];
        end
    end

    // ---------------- stage E: bounds test, u/v divide setup ----------------
    logic signed [48:0] lo_a, hi_a, lo_b, hi_b, diff_a, diff_b;
    logic               bnd_fail;
    side_e_t            e_reg;
    logic [48:0]        e_dvd_a_reg, e_dvd_b_reg;

    assign lo_a   = {{17{first_low_reg[31]}}, first_low_reg};
    assign hi_a   = {{17{first_high_reg[31]}}, first_high_reg};
    assign lo_b   = {{17{second_low_reg[31]}}, second_low_reg};
    assign hi_b   = {{17{second_high_reg[31]}}, second_high_reg};
    assign diff_a = d_reg.p_a - lo_a;
    assign diff_b = d_reg.p_b - lo_b;
    assign bnd_fail = (d_reg.p_a < lo_a) || (d_reg.p_a > hi_a)
                   || (d_reg.p_b < lo_b) || (d_reg.p_b > hi_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_reg <= '0;
        else if (en)
        begin
            e_reg.vld   <= d_reg.vld;
            e_reg.miss  <= d_reg.miss || bnd_fail;
            e_reg.front <= d_reg.front;
            e_reg.t     <= d_reg.t;
            e_reg.p_a   <= d_reg.p_a[31:0];
            e_reg.p_b   <= d_reg.p_b[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // when in bounds the offset fits 33 bits and stays below 2x span
            e_dvd_a_reg <= bnd_fail ? '0 : {diff_a[32:0], 16'b0};
            e_dvd_b_reg <= bnd_fail ? '0 : {diff_b[32:0], 16'b0};
        end
    end

    // ---------------- u / v dividers and delay line ----------------
    logic [UVQW-1:0] u_quo, v_quo;

    rah_div_pipe #(.DVD_W(49), .DVS_W(33), .Q_W(UVQW)) u_div_u
    (
        .clk      (clk),
        .en       (en),
        .dividend (e_dvd_a_reg),
        .divisor  (span_a[32:0]),
        .quotient (u_quo)
    );

    rah_div_pipe #(.DVD_W(49), .DVS_W(33), .Q_W(UVQW)) u_div_v
    (
        .clk      (clk),
        .en       (en),
        .dividend (e_dvd_b_reg),
        .divisor  (span_b[32:0]),
        .quotient (v_quo)
    );

    side_e_t e_dly_reg [UVQW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < UVQW; j++)
                e_dly_reg[j] <= '0;
        end
        else if (en)
        begin
            e_dly_reg[0] <= e_reg;
            for (int j = 1; j < UVQW; j++)
                e_dly_reg[j] <= e_dly_reg[j-1];
        end
    end

    // ---------------- stage F: output word ----------------
    side_e_t            e_out;
    logic               f_hit;
    logic [16:0]        u_next, v_next;
    logic signed [31:0] px_next, py_next, pz_next;

    assign e_out  = e_dly_reg[UVQW-1];
    assign f_hit  = !e_out.miss;
    // zero-width span: point sits on the bound, coordinate reads 0
    assign u_next = (span_a == '0) ? '0 : u_quo;
    assign v_next = (span_b == '0) ? '0 : v_quo;

    always_comb
    begin
        px_next = e_out.p_a;
        py_next = e_out.p_b;
        pz_next = plane_offset_reg;
        case (plane_axis_reg)
            AXIS_XY:
            begin
                px_next = e_out.p_a; py_next = e_out.p_b; pz_next = plane_offset_reg;
            end
            AXIS_XZ:
            begin
                px_next = e_out.p_a; py_next = plane_offset_reg; pz_next = e_out.p_b;
            end
            AXIS_YZ:
            begin
                px_next = plane_offset_reg; py_next = e_out.p_a; pz_next = e_out.p_b;
            end
            default:
            begin
                px_next = '0; py_next = '0; pz_next = '0;
            end
        endcase
    end

    logic               hit_reg, front_reg;
    logic signed [31:0] t_reg, px_reg, py_reg, pz_reg;
    logic [16:0]        u_reg, v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= e_out.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg   <= f_hit;
            front_reg <= f_hit && e_out.front;
            t_reg     <= f_hit ? e_out.t : '0;
            u_reg     <= f_hit ? u_next  : '0;
            v_reg     <= f_hit ? v_next  : '0;
            px_reg    <= f_hit ? px_next : '0;
            py_reg    <= f_hit ? py_next : '0;
            pz_reg    <= f_hit ? pz_next : '0;
        end
    end

    assign out_valid  = out_vld_reg;
    assign hit        = hit_reg;
    assign t_hit      = t_reg;
    assign u_coord    = u_reg;
    assign v_coord    = v_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign point_z    = pz_reg;
    assign front_face = front_reg;

endmodule

// File: verif/ray_axis_aligned_rect_hit_top_test.sv
// Self-checking testbench for ray_axis_aligned_rect_hit_top.
// Depends on rah_pkg (config indexes, plane selectors) and the RTL top level.
`timescale 1ns / 1ps

module ray_axis_aligned_rect_hit_top_test;
    import rah_pkg::*;

    localparam int LATENCY     = 56;
    localparam int IDLE_LIMIT  = 4000;  // cycles with no word moving on either side
    localparam int LONG_HOLD   = 300;   // receiver hold-off, well past pipe depth
    localparam int RAND_WORDS  = 1750;
    localparam longint QONE    = 65536;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz;
        logic signed [31:0] dx, dy, dz;
        logic signed [31:0] t_lo, t_hi;
    } ray_word_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t;
        logic [16:0]        u, v;
        logic signed [31:0] px, py, pz;
        logic               front;
    } rect_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    ray_word_t ray_drv = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rect_result_t res_dut;

    ray_axis_aligned_rect_hit_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .origin_x(ray_drv.ox), .origin_y(ray_drv.oy), .origin_z(ray_drv.oz),
        .dir_x(ray_drv.dx), .dir_y(ray_drv.dy), .dir_z(ray_drv.dz),
        .t_lower(ray_drv.t_lo), .t_upper(ray_drv.t_hi),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(res_dut.hit), .t_hit(res_dut.t),
        .u_coord(res_dut.u), .v_coord(res_dut.v),
        .point_x(res_dut.px), .point_y(res_dut.py), .point_z(res_dut.pz),
        .front_face(res_dut.front)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the rectangle registers
    logic [1:0]         rect_axis   = AXIS_XY;
    logic signed [31:0] rect_offset = 0;
    logic signed [31:0] rect_f_lo   = 0;
    logic signed [31:0] rect_f_hi   = 65536;
    logic signed [31:0] rect_s_lo   = 0;
    logic signed [31:0] rect_s_hi   = 65536;

    ray_word_t    ray_queue[$];
    rect_result_t expected_hits[$];
    int           err_cnt = 0;
    int           rays_accepted = 0;
    int           idle_cycles = 0;

    function automatic longint floor_q16(longint x);
        if (x >= 0)
            return x / QONE;
        return -((-x + (QONE - 1)) / QONE);
    endfunction

    function automatic longint norm_q16(longint p, longint lo, longint hi);
        if (hi - lo <= 0)
            return 0;
        return ((p - lo) * QONE) / (hi - lo);
    endfunction

    // Expected word for one ray against the current rectangle
    function automatic rect_result_t predict_rect_hit(ray_word_t r);
        rect_result_t res;
        longint o[3], d[3], p[3];
        longint k, t;
        int n, a, b;
        res = '0;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        case (rect_axis)
            AXIS_XY: begin n = 2; a = 0; b = 1; end
            AXIS_XZ: begin n = 1; a = 0; b = 2; end
            AXIS_YZ: begin n = 0; a = 1; b = 2; end
            default: return res;    // unused selector: always a miss
        endcase
        if (d[n] == 0)
            return res;             // parallel to the plane
        k = rect_offset;
        t = ((k - o[n]) * QONE) / d[n];
        if (t < longint'(r.t_lo) || t > longint'(r.t_hi))
            return res;
        p[a] = o[a] + floor_q16(t * d[a]);
        p[b] = o[b] + floor_q16(t * d[b]);
        if (p[a] < longint'(rect_f_lo) || p[a] > longint'(rect_f_hi) ||
            p[b] < longint'(rect_s_lo) || p[b] > longint'(rect_s_hi))
            return res;
        p[n] = k;
        res.hit   = 1'b1;
        res.t     = t[31:0];
        res.u     = 17'(norm_q16(p[a], rect_f_lo, rect_f_hi));
        res.v     = 17'(norm_q16(p[b], rect_s_lo, rect_s_hi));
        res.px    = p[0][31:0];
        res.py    = p[1][31:0];
        res.pz    = p[2][31:0];
        res.front = (d[n] < 0);
        return res;
    endfunction

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            err_cnt++;
        end
    endtask

    // Sender: bursts of random length, random gaps in between
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            expected_hits.push_back(predict_rect_hit(ray_drv));
            rays_accepted++;
        end
        if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (ray_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                ray_drv  <= ray_queue.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall density rotates through none, light and heavy; one long hold-off
    int cyc = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk)
    begin
        cyc++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && rays_accepted >= 400)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
            case ((cyc / 400) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) >= 3);
                default: out_ready <= ($urandom_range(0, 9) >= 7);
            endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("result word with nothing expected");
                err_cnt++;
            end
            else
            begin
                rect_result_t e;
                e = expected_hits.pop_front();
                check_field("hit", e.hit, res_dut.hit);
                check_field("t_hit", e.t, res_dut.t);
                check_field("u_coord", e.u, res_dut.u);
                check_field("v_coord", e.v, res_dut.v);
                check_field("point_x", e.px, res_dut.px);
                check_field("point_y", e.py, res_dut.py);
                check_field("point_z", e.pz, res_dut.pz);
                check_field("front_face", e.front, res_dut.front);
            end
        end
    end

    // Watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PLANE_AXIS:   rect_axis   = val[1:0];
            CFG_PLANE_OFFSET: rect_offset = val;
            CFG_FIRST_LOW:    rect_f_lo   = val;
            CFG_FIRST_HIGH:   rect_f_hi   = val;
            CFG_SECOND_LOW:   rect_s_lo   = val;
            CFG_SECOND_HIGH:  rect_s_hi   = val;
            default: ;
        endcase
    endtask

    task automatic set_rect(logic [1:0] ax, int off, int flo, int fhi, int slo, int shi);
        write_cfg(CFG_PLANE_AXIS, ax);
        write_cfg(CFG_PLANE_OFFSET, off);
        write_cfg(CFG_FIRST_LOW, flo);
        write_cfg(CFG_FIRST_HIGH, fhi);
        write_cfg(CFG_SECOND_LOW, slo);
        write_cfg(CFG_SECOND_HIGH, shi);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (ray_queue.size() != 0 || in_valid || expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic ray_word_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                           int tl, int th);
        ray_word_t r;
        r = '{ox, oy, oz, dx, dy, dz, tl, th};
        return r;
    endfunction

    function automatic int rand_span(int lo, int hi);
        int margin;
        margin = (hi - lo) / 4 + 65536;
        return lo - margin + int'($urandom_range(0, (hi - lo) + 2 * margin));
    endfunction

    // Mostly rays aimed near the rectangle, the rest fully random noise
    function automatic ray_word_t gen_ray();
        ray_word_t r;
        int o[3], d[3];
        int n, a, b, tt, tgt_a, tgt_b;
        if ($urandom_range(0, 9) < 3)
        begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
            return r;
        end
        case (rect_axis)
            AXIS_XZ: begin n = 1; a = 0; b = 2; end
            AXIS_YZ: begin n = 0; a = 1; b = 2; end
            default: begin n = 2; a = 0; b = 1; end
        endcase
        tt = $urandom_range(1, 8);
        d[n] = $urandom_range(1, 4 * 65536);
        if ($urandom_range(0, 1)) d[n] = -d[n];
        if ($urandom_range(0, 15) == 0) d[n] = 0;
        d[a] = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 4 * 65536)) - 2 * 65536;
        d[b] = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 4 * 65536)) - 2 * 65536;
        tgt_a = ($urandom_range(0, 5) == 0) ? rect_f_lo : rand_span(rect_f_lo, rect_f_hi);
        tgt_b = ($urandom_range(0, 5) == 0) ? rect_s_hi : rand_span(rect_s_lo, rect_s_hi);
        o[n] = rect_offset - d[n] * tt;
        o[a] = tgt_a - d[a] * tt;
        o[b] = tgt_b - d[b] * tt;
        r.ox = o[0]; r.oy = o[1]; r.oz = o[2];
        r.dx = d[0]; r.dy = d[1]; r.dz = d[2];
        case ($urandom_range(0, 9))
            0:       begin r.t_lo = $urandom; r.t_hi = $urandom; end
            1:       begin r.t_lo = tt * 65536 + 1; r.t_hi = 20 * 65536; end
            2:       begin r.t_lo = 5 * 65536; r.t_hi = -65536; end
            default: begin r.t_lo = 0; r.t_hi = 32'sh7fffffff; end
        endcase
        return r;
    endfunction

    task automatic queue_random(int count);
        repeat (count) ray_queue.push_back(gen_ray());
        drain();
    endtask

    localparam int ONE = 65536;
    localparam int MAXI = 32'sh7fffffff;
    localparam int MINI = 32'sh80000000;

    initial
    begin
        int lo, hi, lo2, hi2;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words on the reset rectangle (unit square in XY at z = 0)
        ray_queue.push_back(make_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, 0, 10 * ONE));
        ray_queue.push_back(make_ray(ONE / 2, ONE / 2, -ONE, 0, 0, ONE, 0, 10 * ONE));
        ray_queue.push_back(make_ray(0, 0, ONE, 0, 0, -ONE, 0, ONE));       // corner low
        ray_queue.push_back(make_ray(ONE, ONE, ONE, 0, 0, -ONE, ONE, ONE)); // corner high, t at both ends
        ray_queue.push_back(make_ray(ONE, ONE, ONE, 0, 0, -ONE, ONE + 1, 2 * ONE)); // t below window
        ray_queue.push_back(make_ray(ONE / 2, ONE / 2, ONE, ONE, 0, 0, 0, MAXI)); // parallel
        ray_queue.push_back(make_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, ONE, 0)); // empty window
        ray_queue.push_back(make_ray(ONE + 1, 0, ONE, 0, 0, -ONE, 0, MAXI)); // just outside
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, 0));
        ray_queue.push_back(make_ray(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI));
        ray_queue.push_back(make_ray(MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI));
        ray_queue.push_back(make_ray(0, 0, MINI, 0, 0, 1, MINI, MAXI));    // t overflows
        ray_queue.push_back(make_ray(-ONE, -ONE, ONE, ONE, ONE, -ONE, 0, MAXI)); // oblique
        ray_queue.push_back(make_ray(-1, -1, -1, -1, -1, -1, -1, -1));
        drain();
        queue_random(150);

        // Unused selector with extreme register values
        set_rect(2'd3, MAXI, MINI, MAXI, MINI, MAXI);
        queue_random(60);
        // Full-range bounds, plane at extreme offsets
        set_rect(AXIS_XY, MAXI, MINI, MAXI, MINI, MAXI);
        queue_random(100);
        set_rect(AXIS_YZ, MINI, MINI, MAXI, MINI, MAXI);
        queue_random(100);
        // Zero-width bounds on both axes
        set_rect(AXIS_XZ, 3 * ONE, ONE, ONE, -2 * ONE, -2 * ONE);
        ray_queue.push_back(make_ray(ONE, 0, -2 * ONE, 0, ONE, 0, 0, MAXI));
        queue_random(100);
        // Inverted bounds
        set_rect(AXIS_XY, -ONE, 2 * ONE, ONE, 0, ONE);
        queue_random(60);
        set_rect(AXIS_XZ, ONE, 0, ONE, 5 * ONE, -5 * ONE);
        queue_random(60);

        // Random rectangles on the three planes
        repeat (9)
        begin
            lo  = int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
            hi  = lo + int'($urandom_range(0, 10 * ONE));
            lo2 = int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
            hi2 = lo2 + int'($urandom_range(0, 10 * ONE));
            set_rect(2'($urandom_range(0, 2)), int'($urandom_range(0, 40 * ONE)) - 20 * ONE,
                     lo, hi, lo2, hi2);
            queue_random((RAND_WORDS - 630) / 9);
        end

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
